[sv/assert_macros.svh]
// Assertion macros used by the checker file sit_checker.sv.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[sv/sit_pkg.sv]
// Package for the segment intersection test: pipeline constants and control type.
// Depends on nothing; used by sit_pipe_ctl and segment_intersection_test.
package sit_pkg;

   localparam int COORD_WIDTH_DEFAULT = 16;
   localparam int NUM_STAGES          = 4;

   // Stage positions along the pipeline
   localparam int STG_DIFF = 0;
   localparam int STG_PROD = 1;
   localparam int STG_FLAG = 2;
   localparam int STG_OUT  = 3;

   // Per-stage load enables from the control block to the datapath
   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
   } sit_ctl_type;

endpackage

[sv/sit_pipe_ctl.sv]
// Valid-bit tracking and stage load enables for the intersection pipeline.
// Depends on sit_pkg.
module sit_pipe_ctl (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_stall,
   input  logic                out_stall,
   output logic                out_valid,
   output sit_pkg::sit_ctl_type ctl
);
   import sit_pkg::*;

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] load;

   // A stage loads when empty or when its contents move on; bubbles collapse
   always_comb begin
      load[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || !out_stall;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
   end

   // Next valid bits
   always_comb begin
      valid_in = valid_ff;
      if (load[0]) begin
         valid_in[0] = in_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
         if (load[k]) begin
            valid_in[k] = valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign ctl.load  = load;
   assign in_stall  = !load[0];
   assign out_valid = valid_ff[NUM_STAGES-1];

endmodule

[sv/segment_intersection_test.sv]
// Segment intersection test: four register stages (differences, products,
// compares, result). An input transfer passes through all four to rsp_valid.
// Throughput is one segment pair per cycle without stalls; an empty stage absorbs a stall.
// Reset (synchronous, active high) clears the stage valid bits only.
// Depends on sit_pkg and sit_pipe_ctl.
module segment_intersection_test #(
   parameter int COORD_WIDTH = sit_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_ax,
   input  logic signed [COORD_WIDTH-1:0] req_ay,
   input  logic signed [COORD_WIDTH-1:0] req_bx,
   input  logic signed [COORD_WIDTH-1:0] req_by_coord,
   input  logic signed [COORD_WIDTH-1:0] req_cx,
   input  logic signed [COORD_WIDTH-1:0] req_cy,
   input  logic signed [COORD_WIDTH-1:0] req_dx,
   input  logic signed [COORD_WIDTH-1:0] req_dy,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_intersects
);
   import sit_pkg::*;

   localparam int W  = COORD_WIDTH;
   localparam int DW = W + 1;       // coordinate difference
   localparam int PW = 2 * DW;      // product of two differences
   localparam int SW = PW + 1;      // sum of two products

   // Difference slots
   localparam int D_DYA = 0;   // dy - ay
   localparam int D_CXA = 1;   // cx - ax
   localparam int D_CYA = 2;   // cy - ay
   localparam int D_DXA = 3;   // dx - ax
   localparam int D_DYB = 4;   // dy - by
   localparam int D_CXB = 5;   // cx - bx
   localparam int D_CYB = 6;   // cy - by
   localparam int D_DXB = 7;   // dx - bx
   localparam int D_BXA = 8;   // bx - ax
   localparam int D_BYA = 9;   // by - ay
   localparam int D_DXC = 10;  // dx - cx
   localparam int D_DYC = 11;  // dy - cy
   localparam int D_AXD = 12;  // ax - dx
   localparam int D_AYD = 13;  // ay - dy
   localparam int NUM_DIFF = 14;
   localparam int NUM_PROD = 20;

   sit_ctl_type ctl;

   logic signed [DW-1:0] diff_in [NUM_DIFF];
   logic signed [DW-1:0] diff_ff [NUM_DIFF];
   logic                 eq1_in, eq1_ff, eq2_ff, eq3_ff;

   logic signed [PW-1:0] prod_in [NUM_PROD];
   logic signed [PW-1:0] prod_ff [NUM_PROD];

   logic signed [SW-1:0] dot_abc, dot_abd, dot_cda;
   logic                 cw_acd_in, cw_bcd_in, cw_abc_in, cw_abd_in;
   logic                 ext_abc_in, ext_abd_in, ext_cda_in;
   logic                 cw_acd_ff, cw_bcd_ff, cw_abc_ff, cw_abd_ff;
   logic                 ext_abc_ff, ext_abd_ff, ext_cda_ff;

   logic                 rsp_intersects_in, rsp_intersects_ff;

   // Valid bits and load enables
   sit_pipe_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .out_stall (rsp_stall),
      .out_valid (rsp_valid),
      .ctl       (ctl)
   );

   // Stage 1: sign-extended coordinate differences and endpoint matches
   always_comb begin
      diff_in[D_DYA] = {req_dy[W-1], req_dy} - {req_ay[W-1], req_ay};
      diff_in[D_CXA] = {req_cx[W-1], req_cx} - {req_ax[W-1], req_ax};
      diff_in[D_CYA] = {req_cy[W-1], req_cy} - {req_ay[W-1], req_ay};
      diff_in[D_DXA] = {req_dx[W-1], req_dx} - {req_ax[W-1], req_ax};
      diff_in[D_DYB] = {req_dy[W-1], req_dy} - {req_by_coord[W-1], req_by_coord};
      diff_in[D_CXB] = {req_cx[W-1], req_cx} - {req_bx[W-1], req_bx};
      diff_in[D_CYB] = {req_cy[W-1], req_cy} - {req_by_coord[W-1], req_by_coord};
      diff_in[D_DXB] = {req_dx[W-1], req_dx} - {req_bx[W-1], req_bx};
      diff_in[D_BXA] = {req_bx[W-1], req_bx} - {req_ax[W-1], req_ax};
      diff_in[D_BYA] = {req_by_coord[W-1], req_by_coord} - {req_ay[W-1], req_ay};
      diff_in[D_DXC] = {req_dx[W-1], req_dx} - {req_cx[W-1], req_cx};
      diff_in[D_DYC] = {req_dy[W-1], req_dy} - {req_cy[W-1], req_cy};
      diff_in[D_AXD] = {req_ax[W-1], req_ax} - {req_dx[W-1], req_dx};
      diff_in[D_AYD] = {req_ay[W-1], req_ay} - {req_dy[W-1], req_dy};
      eq1_in = (req_ax == req_cx && req_ay == req_cy) ||
               (req_bx == req_dx && req_by_coord == req_dy) ||
               (req_ax == req_dx && req_ay == req_dy) ||
               (req_bx == req_cx && req_by_coord == req_cy);
   end

   always_ff @(posedge clock) begin
      if (ctl.load[STG_DIFF]) begin
         diff_ff <= diff_in;
         eq1_ff  <= eq1_in;
      end
   end

   // Stage 2: the twenty cross and dot product terms
   always_comb begin
      // orientation of A and B against CD, of C and D against AB
      prod_in[0]  = PW'(diff_ff[D_DYA]) * PW'(diff_ff[D_CXA]);
      prod_in[1]  = PW'(diff_ff[D_CYA]) * PW'(diff_ff[D_DXA]);
      prod_in[2]  = PW'(diff_ff[D_DYB]) * PW'(diff_ff[D_CXB]);
      prod_in[3]  = PW'(diff_ff[D_CYB]) * PW'(diff_ff[D_DXB]);
      prod_in[4]  = PW'(diff_ff[D_CYA]) * PW'(diff_ff[D_BXA]);
      prod_in[5]  = PW'(diff_ff[D_BYA]) * PW'(diff_ff[D_CXA]);
      prod_in[6]  = PW'(diff_ff[D_DYA]) * PW'(diff_ff[D_BXA]);
      prod_in[7]  = PW'(diff_ff[D_BYA]) * PW'(diff_ff[D_DXA]);
      // C beyond B on line AB
      prod_in[8]  = PW'(diff_ff[D_BXA]) * PW'(diff_ff[D_CYB]);
      prod_in[9]  = PW'(diff_ff[D_BYA]) * PW'(diff_ff[D_CXB]);
      prod_in[10] = PW'(diff_ff[D_BXA]) * PW'(diff_ff[D_CXB]);
      prod_in[11] = PW'(diff_ff[D_BYA]) * PW'(diff_ff[D_CYB]);
      // D beyond B on line AB
      prod_in[12] = PW'(diff_ff[D_BXA]) * PW'(diff_ff[D_DYB]);
      prod_in[13] = PW'(diff_ff[D_BYA]) * PW'(diff_ff[D_DXB]);
      prod_in[14] = PW'(diff_ff[D_BXA]) * PW'(diff_ff[D_DXB]);
      prod_in[15] = PW'(diff_ff[D_BYA]) * PW'(diff_ff[D_DYB]);
      // A beyond D on line CD
      prod_in[16] = PW'(diff_ff[D_DXC]) * PW'(diff_ff[D_AYD]);
      prod_in[17] = PW'(diff_ff[D_DYC]) * PW'(diff_ff[D_AXD]);
      prod_in[18] = PW'(diff_ff[D_DXC]) * PW'(diff_ff[D_AXD]);
      prod_in[19] = PW'(diff_ff[D_DYC]) * PW'(diff_ff[D_AYD]);
   end

   always_ff @(posedge clock) begin
      if (ctl.load[STG_PROD]) begin
         prod_ff <= prod_in;
         eq2_ff  <= eq1_ff;
      end
   end

   // Stage 3: orientation compares, collinearity and positive dot products
   always_comb begin
      dot_abc = SW'(prod_ff[10]) + SW'(prod_ff[11]);
      dot_abd = SW'(prod_ff[14]) + SW'(prod_ff[15]);
      dot_cda = SW'(prod_ff[18]) + SW'(prod_ff[19]);
      cw_acd_in  = prod_ff[0] > prod_ff[1];
      cw_bcd_in  = prod_ff[2] > prod_ff[3];
      cw_abc_in  = prod_ff[4] > prod_ff[5];
      cw_abd_in  = prod_ff[6] > prod_ff[7];
      ext_abc_in = (prod_ff[8] == prod_ff[9]) && !dot_abc[SW-1] && (|dot_abc);
      ext_abd_in = (prod_ff[12] == prod_ff[13]) && !dot_abd[SW-1] && (|dot_abd);
      ext_cda_in = (prod_ff[16] == prod_ff[17]) && !dot_cda[SW-1] && (|dot_cda);
   end

   always_ff @(posedge clock) begin
      if (ctl.load[STG_FLAG]) begin
         cw_acd_ff  <= cw_acd_in;
         cw_bcd_ff  <= cw_bcd_in;
         cw_abc_ff  <= cw_abc_in;
         cw_abd_ff  <= cw_abd_in;
         ext_abc_ff <= ext_abc_in;
         ext_abd_ff <= ext_abd_in;
         ext_cda_ff <= ext_cda_in;
         eq3_ff     <= eq2_ff;
      end
   end

   // Stage 4: combine into the result register
   always_comb begin
      rsp_intersects_in = ((cw_acd_ff != cw_bcd_ff) && (cw_abc_ff != cw_abd_ff)) ||
                          ext_abc_ff || ext_abd_ff || ext_cda_ff || eq3_ff;
   end

   always_ff @(posedge clock) begin
      if (ctl.load[STG_OUT]) begin
         rsp_intersects_ff <= rsp_intersects_in;
      end
   end

   assign rsp_intersects = rsp_intersects_ff;

endmodule

[sv/sit_checker.sv]
// Port-level checks for segment_intersection_test, attached by bind.
// Depends on sit_pkg, assert_macros.svh and segment_intersection_test.
`include "assert_macros.svh"

module sit_checker #(
   parameter int COORD_WIDTH = sit_pkg::COORD_WIDTH_DEFAULT
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic signed [COORD_WIDTH-1:0] req_ax,
   input logic signed [COORD_WIDTH-1:0] req_ay,
   input logic signed [COORD_WIDTH-1:0] req_cx,
   input logic signed [COORD_WIDTH-1:0] req_cy,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic                          rsp_intersects
);

   // A stalled result holds
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_intersects), "stalled result changed")

   // Reset empties the pipeline
   `ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "result valid after reset")

   // With no result pending the pipeline has room
   `ASSERT_CLK(a_no_idle_stall, clock, reset, !rsp_valid |-> !req_stall, "input stalled with empty output")

   // An unstalled transfer reaches rsp_valid if rsp_stall stays low meanwhile
   `ASSERT_CLK(a_latency, clock, reset, (req_valid && !req_stall) ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall |=> rsp_valid, "result missing after four cycles")

   // A shared endpoint A = C always intersects
   `ASSERT_CLK(a_shared_pt, clock, reset, (req_valid && !req_stall && req_ax == req_cx && req_ay == req_cy) ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall |=> rsp_intersects, "shared endpoint not flagged")

endmodule

bind segment_intersection_test sit_checker #(.COORD_WIDTH(COORD_WIDTH)) u_sit_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_ax         (req_ax),
   .req_ay         (req_ay),
   .req_cx         (req_cx),
   .req_cy         (req_cy),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_intersects (rsp_intersects)
);

[sim/testbench.sv]
// Self-checking bench for segment_intersection_test: streams segment pairs in and
// checks every returned intersects flag against a behavioral orientation test.
// Depends on sit_pkg and the segment_intersection_test RTL.
`timescale 1ns / 100ps

module testbench;

   localparam int CW        = sit_pkg::COORD_WIDTH_DEFAULT;
   localparam int N_RANDOM  = 2000;
   localparam int PAUSE_AT  = 900;   // sender drains the block here
   localparam int HOLD_AT   = 300;   // receiver holds off here
   localparam int HOLD_LEN  = 60;
   localparam int QUIET_LO  = 1300;  // no idling on either side in this window
   localparam int QUIET_HI  = 1500;
   localparam int IDLE_PCT  = 31;

   typedef struct {
      logic signed [CW-1:0] ax;
      logic signed [CW-1:0] ay;
      logic signed [CW-1:0] bx;
      logic signed [CW-1:0] by_coord;
      logic signed [CW-1:0] cx;
      logic signed [CW-1:0] cy;
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;
   } seg_pair_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic signed [CW-1:0] req_ax = '0;
   logic signed [CW-1:0] req_ay = '0;
   logic signed [CW-1:0] req_bx = '0;
   logic signed [CW-1:0] req_by_coord = '0;
   logic signed [CW-1:0] req_cx = '0;
   logic signed [CW-1:0] req_cy = '0;
   logic signed [CW-1:0] req_dx = '0;
   logic signed [CW-1:0] req_dy = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_intersects;

   seg_pair_type pair_q[$];    // pairs waiting to be offered
   bit           flag_q[$];    // predicted flags, oldest first
   seg_pair_type cur_pair;

   int pairs_sent = 0;
   int flags_seen = 0;
   int meet_cnt   = 0;
   int apart_cnt  = 0;
   int mismatches = 0;
   int n_directed = 0;
   bit pause_done = 1'b0;
   bit hold_done  = 1'b0;
   int hold_left  = 0;

   segment_intersection_test #(
      .COORD_WIDTH(CW)
   ) i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_ax        (req_ax),
      .req_ay        (req_ay),
      .req_bx        (req_bx),
      .req_by_coord  (req_by_coord),
      .req_cx        (req_cx),
      .req_cy        (req_cy),
      .req_dx        (req_dx),
      .req_dy        (req_dy),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_intersects(rsp_intersects)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor
   // r strictly clockwise of p->q: (q - p) x (r - p) > 0
   function automatic bit is_clockwise(longint px, longint py, longint qx, longint qy,
                                       longint rx, longint ry);
      return (ry - py) * (qx - px) > (qy - py) * (rx - px);
   endfunction

   // r on the line p-q and beyond q seen from p
   function automatic bit runs_past(longint px, longint py, longint qx, longint qy,
                                    longint rx, longint ry);
      longint ux, uy, vx, vy;
      ux = qx - px;
      uy = qy - py;
      vx = rx - qx;
      vy = ry - qy;
      return (ux * vy - uy * vx == 0) && (ux * vx + uy * vy > 0);
   endfunction

   function automatic bit predict_meet(seg_pair_type s);
      longint ax, ay, bx, by, cx, cy, dx, dy;
      bit hit;
      ax = s.ax;
      ay = s.ay;
      bx = s.bx;
      by = s.by_coord;
      cx = s.cx;
      cy = s.cy;
      dx = s.dx;
      dy = s.dy;
      // proper crossing
      hit = (is_clockwise(ax, ay, cx, cy, dx, dy) != is_clockwise(bx, by, cx, cy, dx, dy)) &&
            (is_clockwise(ax, ay, bx, by, cx, cy) != is_clockwise(ax, ay, bx, by, dx, dy));
      // collinear extensions
      hit = hit || runs_past(ax, ay, bx, by, cx, cy) || runs_past(ax, ay, bx, by, dx, dy) ||
            runs_past(cx, cy, dx, dy, ax, ay);
      // shared endpoints
      hit = hit || (ax == cx && ay == cy) || (bx == dx && by == dy) ||
            (ax == dx && ay == dy) || (bx == cx && by == cy);
      return hit;
   endfunction

   // ---------------------------------------------------------------- stimulus
   task automatic add_pair(int ax, int ay, int bx, int by, int cx, int cy, int dx, int dy);
      seg_pair_type s;
      s.ax = CW'(ax);
      s.ay = CW'(ay);
      s.bx = CW'(bx);
      s.by_coord = CW'(by);
      s.cx = CW'(cx);
      s.cy = CW'(cy);
      s.dx = CW'(dx);
      s.dy = CW'(dy);
      pair_q.insert(pair_q.size(), s);
   endtask

   function automatic int spread(int half);
      return int'($urandom_range(2 * half)) - half;
   endfunction

   function automatic seg_pair_type random_pair();
      seg_pair_type s;
      int sel, ox, oy, ux, uy, k;
      sel = $urandom_range(99);
      if (sel < 35) begin
         // any bit pattern
         s.ax = CW'($urandom());
         s.ay = CW'($urandom());
         s.bx = CW'($urandom());
         s.by_coord = CW'($urandom());
         s.cx = CW'($urandom());
         s.cy = CW'($urandom());
         s.dx = CW'($urandom());
         s.dy = CW'($urandom());
      end else if (sel < 55) begin
         // tight cluster: many orientation ties
         ox = spread(30000);
         oy = spread(30000);
         s.ax = CW'(ox + spread(8));
         s.ay = CW'(oy + spread(8));
         s.bx = CW'(ox + spread(8));
         s.by_coord = CW'(oy + spread(8));
         s.cx = CW'(ox + spread(8));
         s.cy = CW'(oy + spread(8));
         s.dx = CW'(ox + spread(8));
         s.dy = CW'(oy + spread(8));
      end else if (sel < 75) begin
         // all four points on one line
         ox = spread(30000);
         oy = spread(30000);
         ux = spread(50);
         uy = spread(50);
         k = spread(20); s.ax = CW'(ox + k * ux); s.ay = CW'(oy + k * uy);
         k = spread(20); s.bx = CW'(ox + k * ux); s.by_coord = CW'(oy + k * uy);
         k = spread(20); s.cx = CW'(ox + k * ux); s.cy = CW'(oy + k * uy);
         k = spread(20); s.dx = CW'(ox + k * ux); s.dy = CW'(oy + k * uy);
      end else begin
         // medium range, often with a shared or degenerate endpoint
         s.ax = CW'(spread(2000));
         s.ay = CW'(spread(2000));
         s.bx = CW'(spread(2000));
         s.by_coord = CW'(spread(2000));
         s.cx = CW'(spread(2000));
         s.cy = CW'(spread(2000));
         s.dx = CW'(spread(2000));
         s.dy = CW'(spread(2000));
         case ($urandom_range(5))
            0: begin s.cx = s.ax; s.cy = s.ay; end
            1: begin s.dx = s.bx; s.dy = s.by_coord; end
            2: begin s.dx = s.ax; s.dy = s.ay; end
            3: begin s.cx = s.bx; s.cy = s.by_coord; end
            4: begin s.bx = s.ax; s.by_coord = s.ay; end
            default: ;
         endcase
      end
      return s;
   endfunction

   // ---------------------------------------------------------------- driver
   always @(posedge clock) begin
      bit quiet, idle, may_send;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            flag_q.insert(flag_q.size(), predict_meet(cur_pair));
            pairs_sent++;
         end
         // sender pause: wait for the block to drain completely once
         if (pairs_sent == PAUSE_AT && !pause_done && flag_q.size() == 0)
            pause_done = 1'b1;
         may_send = pause_done || pairs_sent != PAUSE_AT;
         quiet = pairs_sent >= QUIET_LO && pairs_sent < QUIET_HI;
         idle  = !quiet && ($urandom_range(99) < IDLE_PCT);
         if (!req_valid || !req_stall) begin
            if (pair_q.size() != 0 && may_send && !idle) begin
               cur_pair = pair_q.pop_front();
               req_ax       <= cur_pair.ax;
               req_ay       <= cur_pair.ay;
               req_bx       <= cur_pair.bx;
               req_by_coord <= cur_pair.by_coord;
               req_cx       <= cur_pair.cx;
               req_cy       <= cur_pair.cy;
               req_dx       <= cur_pair.dx;
               req_dy       <= cur_pair.dy;
               req_valid    <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor
   always @(posedge clock) begin
      bit want;
      bit quiet;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (flag_q.size() == 0) begin
               $error("intersects: unexpected transfer, actual %0d", rsp_intersects);
               mismatches++;
            end else begin
               want = flag_q.pop_front();
               if (rsp_intersects !== want) begin
                  $error("intersects mismatch: expected %0d, actual %0d", want, rsp_intersects);
                  mismatches++;
               end
               if (want) meet_cnt++;
               else      apart_cnt++;
            end
            flags_seen++;
         end
         // long hold-off once, otherwise random stalls outside the quiet window
         quiet = flags_seen >= QUIET_LO && flags_seen < QUIET_HI;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (flags_seen == HOLD_AT && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_LEN - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
         end
      end
   end

   // ---------------------------------------------------------------- sequence
   initial begin
      // directed pairs
      add_pair(-10, 0, 10, 0, 0, -10, 0, 10);          // proper crossing
      add_pair(0, 0, 10, 0, 0, 5, 10, 5);              // parallel, apart
      add_pair(0, 0, 5, 0, 9, 0, 9, 7);                // C extends AB
      add_pair(0, 0, 3, 3, -20, 40, 7, 7);             // D extends AB
      add_pair(30, 1, 0, 9, 0, 0, 0, 4);               // B extends CD
      add_pair(4, 4, 20, -3, 4, 4, -9, 11);            // A equals C
      add_pair(-7, 2, 15, 15, 100, -50, 15, 15);       // B equals D
      add_pair(6, -6, 1, 9, 40, 40, 6, -6);            // A equals D
      add_pair(-3, 8, 12, 12, 12, 12, 90, -90);        // B equals C
      add_pair(0, 0, 10, 0, 5, 0, 5, 8);               // C on AB: orientation tie
      add_pair(0, 0, 10, 0, 5, -8, 5, 0);              // D on AB: orientation tie
      add_pair(3, 3, 3, 3, 3, 3, 3, 3);                // both degenerate, same point
      add_pair(1, 1, 1, 1, -5, 0, 5, 0);               // degenerate AB off CD
      add_pair(0, 0, 10, 0, 2, 0, 8, 0);               // collinear overlap, no extension
      add_pair(0, 0, 1, 0, 100, 0, 200, 0);            // collinear, far extension
      add_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
      add_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
      add_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
      add_pair(32767, -32768, -32768, 32767, 0, 0, 1, 1);
      add_pair(-32768, 0, 32767, 0, -32768, 1, 32767, 1);
      add_pair(32767, 32767, -32768, -32768, 0, 1, 1, 2);
      n_directed = pair_q.size();
      for (int i = 0; i < N_RANDOM; i++)
         pair_q.insert(pair_q.size(), random_pair());

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (pair_q.size() != 0 || req_valid) @(posedge clock);
      while (flag_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Checked %0d segment pairs (%0d directed, %0d random): %0d meet, %0d apart.",
               flags_seen, n_directed, flags_seen - n_directed, meet_cnt, apart_cnt);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

[segment_intersection_test.f]
+incdir+sv
sv/sit_pkg.sv
sv/sit_pipe_ctl.sv
sv/segment_intersection_test.sv
sv/sit_checker.sv
sim/testbench.sv
